// ===== hw/rtl/hatc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the address tag checker.
package hatc_pkg;

	// Hash constants of the splitmix64 finaliser.
	localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MUL_ONE    = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MUL_TWO    = 64'h94d049bb133111eb;
	localparam logic [63:0] SEED_RESET = 64'h5da9f0e3c17b2846;

	// Shift amounts of the xor-shift folds.
	localparam int unsigned SHIFT_LOAD = 30;
	localparam int unsigned SHIFT_ONE  = 27;
	localparam int unsigned SHIFT_TWO  = 31;

	// Counter limits.
	localparam logic [12:0] REPORT_CAP   = 13'd4096;
	localparam logic [26:0] MISMATCH_CAP = 27'd67108864;

	// Operation codes.
	localparam logic [1:0] FUNC_GENERATE = 2'd0;
	localparam logic [1:0] FUNC_CHECK    = 2'd1;
	localparam logic [1:0] FUNC_CLEAR    = 2'd2;

	// Register indexes, taken from address bit 3.
	localparam logic REG_SEED  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	// Which 32x32 partial product of a 64-bit multiply is formed.
	typedef enum logic [1:0] {
		PART_LL,
		PART_LH,
		PART_HL
	} hatc_part_t;

	// Which of the two multiply-and-fold rounds is running.
	typedef enum logic {
		ROUND_ONE,
		ROUND_TWO
	} hatc_round_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        load;
		logic        mul_en;
		hatc_part_t  part;
		hatc_round_t round;
		logic        acc_en;
		logic        mix_en;
		logic        finish;
	} hatc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_blocked;
	} hatc_status_t;

endpackage

// ===== hw/rtl/hatc_ctrl.sv =====
// Controller state machine that sequences the hash rounds and the result write.
module hatc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  hatc_pkg::hatc_status_t status,
	output hatc_pkg::hatc_cmd_t    cmd
);
	import hatc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LL,
		S_LH,
		S_HL,
		S_FOLD,
		S_FIN
	} state_t;

	state_t      state_q;
	hatc_round_t round_q;

	assign in_ready = (state_q == S_IDLE);

	// Decode the current step into datapath commands.
	always_comb begin
		cmd        = '0;
		cmd.round  = round_q;
		cmd.part   = PART_LL;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_LL: begin
				cmd.mul_en = 1'b1;
				cmd.part   = PART_LL;
			end
			S_LH: begin
				cmd.mul_en = 1'b1;
				cmd.part   = PART_LH;
				cmd.acc_en = 1'b1;
			end
			S_HL: begin
				cmd.mul_en = 1'b1;
				cmd.part   = PART_HL;
				cmd.acc_en = 1'b1;
			end
			S_FOLD: begin
				cmd.acc_en = 1'b1;
				cmd.mix_en = 1'b1;
			end
			S_FIN: begin
				cmd.finish = !status.out_blocked;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	// State and round register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			round_q <= ROUND_ONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LL;
						round_q <= ROUND_ONE;
					end
				end
				S_LL: begin
					state_q <= S_LH;
				end
				S_LH: begin
					state_q <= S_HL;
				end
				S_HL: begin
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (round_q == ROUND_ONE) begin
						state_q <= S_LL;
						round_q <= ROUND_TWO;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!status.out_blocked) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/hatc_datapath.sv =====
// Datapath: tag hash with a shared 32x32 multiplier, compare, counters and result register.
module hatc_datapath #(
	parameter int unsigned ADDR_BITS  = 32,
	parameter int unsigned LINE_SHIFT = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hatc_pkg::hatc_cmd_t    cmd,
	output hatc_pkg::hatc_status_t status,
	input  logic [63:0]            seed,
	input  logic [12:0]            report_limit,
	input  logic [1:0]             func,
	input  logic [31:0]            offset,
	input  logic [63:0]            observed,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [63:0]            expected_tag,
	output logic                   mismatch,
	output logic                   report,
	output logic [26:0]            mismatch_count,
	output logic [12:0]            reported_count
);
	import hatc_pkg::*;

	localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;
	localparam logic [63:0] LINE_MASK = ~((64'd1 << LINE_SHIFT) - 64'd1);

	logic [1:0]  func_q;
	logic [63:0] observed_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	hatc_part_t  prod_part_q;
	logic [26:0] mismatch_total_q;
	logic [12:0] report_total_q;
	logic        out_valid_q;
	logic [63:0] expected_tag_q;
	logic        mismatch_q;
	logic        report_q;

	logic [63:0] line;
	logic [63:0] seeded;
	logic [63:0] const_sel;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_d;
	logic [63:0] acc_next;
	logic [63:0] mix_val;
	logic [12:0] limit_eff;
	logic        miss;
	logic        rep;

	// Line base offset mixed with the seed and the golden increment.
	assign line   = {32'd0, offset} & ADDR_MASK & LINE_MASK;
	assign seeded = (line ^ seed) + GOLDEN_INC;

	// Operand selection for the shared multiplier.
	assign const_sel = (cmd.round == ROUND_ONE) ? MUL_ONE : MUL_TWO;
	always_comb begin
		case (cmd.part)
			PART_LL: begin
				mul_a = x_q[31:0];
				mul_b = const_sel[31:0];
			end
			PART_LH: begin
				mul_a = x_q[31:0];
				mul_b = const_sel[63:32];
			end
			PART_HL: begin
				mul_a = x_q[63:32];
				mul_b = const_sel[31:0];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = const_sel[31:0];
			end
		endcase
	end
	assign prod_d = {32'd0, mul_a} * {32'd0, mul_b};

	// Accumulate the registered partial product; cross terms land in the upper word.
	always_comb begin
		case (prod_part_q)
			PART_LL: begin
				acc_next = prod_q;
			end
			PART_LH, PART_HL: begin
				acc_next = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
			end
			default: begin
				acc_next = prod_q;
			end
		endcase
	end
	assign mix_val = (cmd.round == ROUND_ONE) ? (acc_next ^ (acc_next >> SHIFT_ONE))
	                                          : (acc_next ^ (acc_next >> SHIFT_TWO));

	// Check and report decision for the finished tag.
	assign limit_eff = (report_limit > REPORT_CAP) ? REPORT_CAP : report_limit;
	assign miss      = (func_q == FUNC_CHECK) && (observed_q != x_q);
	assign rep       = miss && (report_total_q < limit_eff);

	// Hash working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= func;
			observed_q <= observed;
			x_q        <= seeded ^ (seeded >> SHIFT_LOAD);
		end else if (cmd.mix_en) begin
			x_q <= mix_val;
		end
		if (cmd.mul_en) begin
			prod_q      <= prod_d;
			prod_part_q <= cmd.part;
		end
		if (cmd.acc_en) begin
			acc_q <= acc_next;
		end
	end

	// Mismatch and report counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_total_q <= '0;
			report_total_q   <= '0;
		end else if (cmd.finish) begin
			case (func_q)
				FUNC_CHECK: begin
					if (miss && (mismatch_total_q < MISMATCH_CAP)) begin
						mismatch_total_q <= mismatch_total_q + 27'd1;
					end
					if (rep) begin
						report_total_q <= report_total_q + 13'd1;
					end
				end
				FUNC_CLEAR: begin
					mismatch_total_q <= '0;
					report_total_q   <= '0;
				end
				default: begin
					report_total_q <= report_total_q;
				end
			endcase
		end
	end

	// Result register; it holds a finished transaction until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			expected_tag_q <= x_q;
			mismatch_q     <= miss;
			report_q       <= rep;
		end
	end

	assign status.out_blocked = out_valid_q && !out_ready;
	assign out_valid          = out_valid_q;
	assign expected_tag       = expected_tag_q;
	assign mismatch           = mismatch_q;
	assign report             = report_q;
	assign mismatch_count     = mismatch_total_q;
	assign reported_count     = report_total_q;

	// The mismatch counter never passes its saturation value.
	assert property (@(posedge clk) disable iff (!arst_n)
		mismatch_total_q <= MISMATCH_CAP)
		else $error("mismatch counter above saturation value");

	// Every reported mismatch was also counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		report_total_q <= mismatch_total_q)
		else $error("report counter ahead of mismatch counter");

	// A reported result must be a mismatch.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && report_q) |-> mismatch_q)
		else $error("report flagged without mismatch");

	// A result is only written when the result register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && !out_ready))
		else $error("result overwritten while still pending");

	// A written result is presented on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished transaction not presented");

endmodule

// ===== hw/rtl/hashed_address_tag_checker.sv =====
// Top level of the address tag checker: configuration registers, controller and datapath.
// Each accepted transaction steps through LL, LH, HL and FOLD for each of two rounds, then FIN,
// which writes the result register once the output is not blocked. The shared 32x32 multiplier
// forms three partial products per 64-bit multiply; a new input is taken only after FIN.
// A pending result waits in the output register while the next transaction is hashed.
// Reset (asynchronous, active low) clears both counters and loads the default seed and limit.
module hashed_address_tag_checker #(
	parameter int unsigned ADDR_BITS  = 32,
	parameter int unsigned LINE_SHIFT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] offset,
	input  logic [63:0] observed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] expected_tag,
	output logic        mismatch,
	output logic        report,
	output logic [26:0] mismatch_count,
	output logic [12:0] reported_count
);
	import hatc_pkg::*;

	logic [63:0]  seed_q;
	logic [12:0]  report_limit_q;
	logic         wr_en;
	hatc_cmd_t    cmd;
	hatc_status_t status;

	// Register writes complete on the access phase.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q         <= SEED_RESET;
			report_limit_q <= REPORT_CAP;
		end else if (wr_en) begin
			case (paddr[3])
				REG_SEED: begin
					seed_q <= pwdata;
				end
				REG_LIMIT: begin
					report_limit_q <= pwdata[12:0];
				end
				default: begin
					seed_q <= seed_q;
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3])
			REG_SEED: begin
				prdata = seed_q;
			end
			REG_LIMIT: begin
				prdata = {51'd0, report_limit_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	hatc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	hatc_datapath #(
		.ADDR_BITS  (ADDR_BITS),
		.LINE_SHIFT (LINE_SHIFT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.seed           (seed_q),
		.report_limit   (report_limit_q),
		.func           (func),
		.offset         (offset),
		.observed       (observed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.expected_tag   (expected_tag),
		.mismatch       (mismatch),
		.report         (report),
		.mismatch_count (mismatch_count),
		.reported_count (reported_count)
	);

endmodule

// ===== tb/hatc_tag_monitor.sv =====
// Tag hash for the testbench, and the monitor that predicts and checks the tag checker's results.
package hatc_tb_pkg;
	import hatc_pkg::*;

	// Line granularity of the tagged region; the offset port is already ADDR_BITS wide.
	localparam int unsigned LINE_SHIFT = 6;

	// Operation code with no function of its own; the block treats it as generate.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	// Byte addresses of the registers on the configuration port.
	localparam logic [3:0] SEED_ADDR  = {REG_SEED, 3'b000};
	localparam logic [3:0] LIMIT_ADDR = {REG_LIMIT, 3'b000};

	// Tag of the line that holds a byte offset: splitmix64 finaliser of the line base XOR seed plus the golden increment.
	function automatic logic [63:0] hash_line_tag(logic [63:0] seed, logic [31:0] off);
		logic [63:0] x;
		x = {32'd0, off & ~32'((1 << LINE_SHIFT) - 1)};
		x = (x ^ seed) + GOLDEN_INC;
		x = (x ^ (x >> SHIFT_LOAD)) * MUL_ONE;
		x = (x ^ (x >> SHIFT_ONE)) * MUL_TWO;
		return x ^ (x >> SHIFT_TWO);
	endfunction

endpackage

module hatc_tag_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] offset,
	input  logic [63:0] observed,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] expected_tag,
	input  logic        mismatch,
	input  logic        report,
	input  logic [26:0] mismatch_count,
	input  logic [12:0] reported_count,
	output int          fails,
	output int          waiting
);
	import hatc_pkg::*;
	import hatc_tb_pkg::*;

	// One awaited result.
	typedef struct {
		logic [63:0] tag;
		logic        miss;
		logic        rep;
		logic [26:0] mismatches;
		logic [12:0] reports;
	} line_result_t;

	line_result_t results_due[$];
	line_result_t oldest;

	// Shadow of the registers and counters of the block.
	logic [63:0] seed_q;
	logic [12:0] limit_q;
	logic [26:0] mismatch_total;
	logic [12:0] report_total;

	// Works out the result of one transaction and advances the shadow counters.
	function automatic line_result_t predict_line(logic [1:0] f, logic [31:0] off,
			logic [63:0] obs);
		line_result_t r;
		logic [12:0] limit_eff;
		limit_eff = (limit_q > REPORT_CAP) ? REPORT_CAP : limit_q;
		r.tag = hash_line_tag(seed_q, off);
		r.miss = 1'b0;
		r.rep = 1'b0;
		case (f)
			FUNC_CHECK: begin
				if (obs != r.tag) begin
					r.miss = 1'b1;
					if (mismatch_total < MISMATCH_CAP)
						mismatch_total = mismatch_total + 27'd1;
					if (report_total < limit_eff) begin
						r.rep = 1'b1;
						report_total = report_total + 13'd1;
					end
				end
			end
			FUNC_CLEAR: begin
				mismatch_total = '0;
				report_total = '0;
			end
			default: ;
		endcase
		r.mismatches = mismatch_total;
		r.reports = report_total;
		return r;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			fails++;
		end
	endtask

	initial begin
		fails = 0;
		waiting = 0;
	end

	// Follow register writes, retire results in order and predict each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q = SEED_RESET;
			limit_q = REPORT_CAP;
			mismatch_total = '0;
			report_total = '0;
			results_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == SEED_ADDR)
					seed_q = pwdata;
				else if (paddr == LIMIT_ADDR)
					limit_q = pwdata[12:0];
			end
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result with none awaited, expected nothing, got tag %h",
						$time, expected_tag);
					fails++;
				end else begin
					oldest = results_due.pop_front();
					compare_field("expected_tag", oldest.tag, expected_tag);
					compare_field("mismatch", 64'(oldest.miss), 64'(mismatch));
					compare_field("report", 64'(oldest.rep), 64'(report));
					compare_field("mismatch_count", 64'(oldest.mismatches),
						64'(mismatch_count));
					compare_field("reported_count", 64'(oldest.reports),
						64'(reported_count));
				end
			end
			if (in_valid && in_ready)
				results_due.push_back(predict_line(func, offset, observed));
		end
		waiting = results_due.size();
	end

endmodule

// ===== tb/hashed_address_tag_checker_tb.sv =====
// Testbench top for the address tag checker: clock, reset, stimulus, register writes and verdict.
module hashed_address_tag_checker_tb;
	import hatc_pkg::*;
	import hatc_tb_pkg::*;

	localparam int ITEMS_PER_PHASE = 225;
	localparam int HOLD_PHASE      = 2;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE          = 20;
	localparam int RUN_LIMIT       = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [31:0] offset;
	logic [63:0] observed;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] expected_tag;
	logic        mismatch;
	logic        report;
	logic [26:0] mismatch_count;
	logic [12:0] reported_count;
	int          fails;
	int          waiting;

	// Stimulus bookkeeping.
	logic [63:0] cur_seed;
	int          phase_no = 0;
	int          send_idle = 31;
	int          recv_idle = 45;
	int          func_seen [4];
	int          cycles = 0;

	hashed_address_tag_checker u_top (.*);
	hatc_tag_monitor u_mon (.*);

	always #2 clk = ~clk;

	// The run is abandoned if it outlasts any correct run by a wide margin.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: random back-pressure, plus one long hold-off so that the block fills up.
	initial begin
		int held;
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_no == HOLD_PHASE && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Offers one transaction, with a random gap first, and returns once it is accepted.
	task automatic send_item(logic [1:0] f, logic [31:0] off, logic [63:0] obs);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		offset <= off;
		observed <= obs;
		do @(posedge clk); while (!in_ready);
		func_seen[f]++;
	endtask

	// Stops offering and waits until every awaited result has come out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [3:0] addr, logic [63:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random traffic: mostly sweeps of consecutive lines read back largely intact, some noise.
	task automatic random_traffic(int count);
		int sent;
		int run_len;
		int k;
		int pick;
		logic [31:0] base;
		logic [31:0] off;
		logic [63:0] good;
		logic [63:0] obs;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 70) begin
				run_len = $urandom_range(24, 4);
				base = $urandom;
				for (k = 0; k < run_len; k++) begin
					off = base + 32'(k) * 32'd64;
					if ($urandom_range(9) == 0)
						off[5:0] = 6'($urandom);
					good = hash_line_tag(cur_seed, off);
					pick = $urandom_range(99);
					if (pick < 80)
						obs = good;
					else if (pick < 92)
						obs = good ^ (64'd1 << $urandom_range(63));
					else
						obs = {$urandom, $urandom};
					send_item(FUNC_CHECK, off, obs);
				end
				sent += run_len;
				// Sometimes a new pass starts after the sweep.
				if ($urandom_range(3) == 0) begin
					send_item(FUNC_CLEAR, $urandom, {$urandom, $urandom});
					sent++;
				end
			end else begin
				send_item(2'($urandom), $urandom, {$urandom, $urandom});
				sent++;
			end
		end
	endtask

	// One register setting: drain, reprogram while idle, then random traffic.
	task automatic run_phase(int idx, logic [63:0] seed, logic [12:0] limit);
		drain();
		phase_no = idx;
		if (idx < 4) begin
			send_idle = 31;
			recv_idle = 45;
		end else if (idx < 7) begin
			send_idle = 45;
			recv_idle = 31;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		write_reg(SEED_ADDR, seed);
		write_reg(LIMIT_ADDR, {51'd0, limit});
		cur_seed = seed;
		random_traffic(ITEMS_PER_PHASE);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FUNC_GENERATE;
		offset = '0;
		observed = '0;
		cur_seed = SEED_RESET;
		foreach (func_seen[i])
			func_seen[i] = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset seed and limit.
		send_item(FUNC_GENERATE, 32'h0000_0000, '0);
		send_item(FUNC_GENERATE, 32'hFFFF_FFFF, '1);
		send_item(FUNC_GENERATE, 32'h0000_003F, '0);
		send_item(FUNC_SPARE, 32'h1234_5678, '1);
		send_item(FUNC_CHECK, 32'h0000_0000, hash_line_tag(cur_seed, 32'h0000_0000));
		send_item(FUNC_CHECK, 32'h0000_0000, '0);
		send_item(FUNC_CHECK, 32'hFFFF_FFFF, '1);
		send_item(FUNC_CHECK, 32'h0000_0040, hash_line_tag(cur_seed, 32'h0000_0040) ^ 64'd1);
		send_item(FUNC_CLEAR, 32'h0000_0080, 64'hDEAD_BEEF_0123_4567);
		send_item(FUNC_CHECK, 32'hFFFF_FFC0, hash_line_tag(cur_seed, 32'hFFFF_FFC0));
		// A misaligned offset must hit the tag of its line base.
		send_item(FUNC_CHECK, 32'h0000_1001, hash_line_tag(cur_seed, 32'h0000_1000));
		send_item(FUNC_CHECK, 32'h8000_0000,
			hash_line_tag(cur_seed, 32'h8000_0000) ^ 64'h8000_0000_0000_0000);
		send_item(FUNC_GENERATE, 32'h8000_0000, '0);
		send_item(FUNC_SPARE, 32'h0000_0040, '0);
		send_item(FUNC_CHECK, 32'h7FFF_FFFF, '0);
		send_item(FUNC_CLEAR, 32'hFFFF_FFFF, '1);
		send_item(FUNC_CHECK, 32'h0000_2000, '1);

		// Register settings, extremes of seed and report limit among them.
		run_phase(1, 64'd0, 13'd0);
		run_phase(2, '1, 13'd8191);
		run_phase(3, {$urandom, $urandom}, 13'd1);
		run_phase(4, {$urandom, $urandom}, REPORT_CAP);
		run_phase(5, SEED_RESET, REPORT_CAP + 13'd1);
		run_phase(6, {$urandom, $urandom}, 13'd3);
		run_phase(7, {$urandom, $urandom}, 13'($urandom_range(8191)));
		run_phase(8, {$urandom, $urandom}, 13'd2);

		drain();
		repeat (SETTLE) @(negedge clk);
		$display("Covered %0d generate, %0d check, %0d clear and %0d spare-code transactions.",
			func_seen[FUNC_GENERATE], func_seen[FUNC_CHECK], func_seen[FUNC_CLEAR],
			func_seen[FUNC_SPARE]);
		$display("Nine register settings, report limits 0 to 8191, one long output hold-off.");
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
